// ===== rtl/drt_pkg.sv =====
package drt_pkg;

  // Surface dimension ceiling; larger register values saturate to this
  localparam int MAX_DIM = 4096;
  localparam int POS_W   = 12;
  localparam int DIM_W   = 13;
  localparam int AREA_W  = 2 * DIM_W;
  localparam int FULL_W  = 25;
  localparam int CNT_W   = 64;

  // Event codes carried on in_tuser
  typedef enum logic [1:0] {
    OP_MARK_RECT = 2'd0,
    OP_MARK_FULL = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_FLIP      = 2'd3
  } op_t;

  // Present classification carried on out_tuser
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_PARTIAL = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_SURF_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_SURF_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_PARTIAL_OK  = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] top;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             full;
  } region_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic signed [15:0] width;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } rect_t;

  typedef struct packed {
    kind_t            kind;
    logic             have;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] top;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } result_t;

  // Saturate a surface dimension to MAX_DIM
  function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

endpackage

// ===== rtl/dirty_rect_tracker_top.sv =====
// An accepted transaction moves from the input register to the out_* result register on advance.
// Throughput: one event per cycle unless out_tready stalls; the clip, merge, one 13x13 multiply
// and area compare sit between the input register and the result register.
// The full-surface area is registered from the saturated surface size registers.
// Reset (rst_n low, synchronous) empties the region, zeroes all counters and totals,
// and loads enable 0, surface 1024x768, partial presents supported.
module dirty_rect_tracker_top
  import drt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // rect_left, rect_top, rect_width, rect_height
  input  logic [63:0]  in_tdata,
  // op
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // has_region, out_left, out_top, out_width, out_height, count_total, count_empty,
  // count_partial, count_full, pixels_partial, pixels_full, zero pad
  output logic [439:0] out_tdata,
  // flip_kind
  output logic [1:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_wdata
);

  logic              enable_r, partial_ok_r;
  logic [DIM_W-1:0]  surf_w_r, surf_h_r, sw_sat, sh_sat;
  logic [FULL_W-1:0] full_area_r;
  logic [AREA_W-1:0] full_prod;

  logic              in_valid_r, out_valid_r, advance;
  op_t               op_r;
  rect_t             rect_r;
  region_t           region_r, region_nxt;
  result_t           result, result_r;
  logic [AREA_W-1:0] area;

  logic [CNT_W-1:0]  flips_total_r, flips_empty_r, flips_partial_r, flips_full_r;
  logic [CNT_W-1:0]  area_partial_r, area_full_r;
  logic [CNT_W-1:0]  flips_total_nxt, flips_empty_nxt, flips_partial_nxt, flips_full_nxt;
  logic [CNT_W-1:0]  area_partial_nxt, area_full_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      surf_w_r     <= DIM_W'(1024);
      surf_h_r     <= DIM_W'(768);
      partial_ok_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ENABLE:      enable_r     <= cfg_wdata[0];
        CFG_SURF_WIDTH:  surf_w_r     <= cfg_wdata;
        CFG_SURF_HEIGHT: surf_h_r     <= cfg_wdata;
        CFG_PARTIAL_OK:  partial_ok_r <= cfg_wdata[0];
        default:         enable_r     <= enable_r;
      endcase
    end
  end

  // Precompute the saturated full-surface area
  assign sw_sat    = dim_sat(surf_w_r);
  assign sh_sat    = dim_sat(surf_h_r);
  assign full_prod = sw_sat * sh_sat;

  always_ff @(posedge clk) begin
    full_area_r <= full_prod[FULL_W-1:0];
  end

  // Handshake: advance when the result register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= op_t'(in_tuser);
      rect_r <= rect_t'(in_tdata);
    end
  end

  drt_event u_event (
    .op         (op_r),
    .rect       (rect_r),
    .region     (region_r),
    .enable     (enable_r),
    .partial_ok (partial_ok_r),
    .surf_w     (sw_sat),
    .surf_h     (sh_sat),
    .full_area  (full_area_r),
    .region_nxt (region_nxt),
    .result     (result),
    .area       (area)
  );

  // Bump flip counters and pixel totals by classification
  always_comb begin
    flips_total_nxt   = flips_total_r;
    flips_empty_nxt   = flips_empty_r;
    flips_partial_nxt = flips_partial_r;
    flips_full_nxt    = flips_full_r;
    area_partial_nxt  = area_partial_r;
    area_full_nxt     = area_full_r;
    case (result.kind)
      KIND_EMPTY: begin
        flips_total_nxt = flips_total_r + 1'b1;
        flips_empty_nxt = flips_empty_r + 1'b1;
      end
      KIND_PARTIAL: begin
        flips_total_nxt   = flips_total_r + 1'b1;
        flips_partial_nxt = flips_partial_r + 1'b1;
        area_partial_nxt  = area_partial_r + CNT_W'(area);
      end
      KIND_FULL: begin
        flips_total_nxt = flips_total_r + 1'b1;
        flips_full_nxt  = flips_full_r + 1'b1;
        area_full_nxt   = area_full_r + CNT_W'(full_area_r);
      end
      default: begin
        flips_total_nxt = flips_total_r;
      end
    endcase
  end

  // State and counters move only with a transaction entering the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r        <= '0;
      flips_total_r   <= '0;
      flips_empty_r   <= '0;
      flips_partial_r <= '0;
      flips_full_r    <= '0;
      area_partial_r  <= '0;
      area_full_r     <= '0;
    end else if (advance) begin
      region_r        <= region_nxt;
      flips_total_r   <= flips_total_nxt;
      flips_empty_r   <= flips_empty_nxt;
      flips_partial_r <= flips_partial_nxt;
      flips_full_r    <= flips_full_nxt;
      area_partial_r  <= area_partial_nxt;
      area_full_r     <= area_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result_r <= result;
  end

  // Counters hold while the result waits, so they feed the output directly
  assign out_tvalid = out_valid_r;
  assign out_tuser  = result_r.kind;
  assign out_tdata  = {5'b0, area_full_r, area_partial_r, flips_full_r, flips_partial_r,
                       flips_empty_r, flips_total_r, result_r.height, result_r.width,
                       result_r.top, result_r.left, result_r.have};

`ifndef SYNTH
  a_flip_clears_region: assert property (@(posedge clk) disable iff (!rst_n)
    advance && op_r == OP_FLIP && enable_r |=> region_r == '0)
    else $error("region not emptied after flip");

  a_flip_counts_once: assert property (@(posedge clk) disable iff (!rst_n)
    advance && op_r == OP_FLIP && enable_r |=> flips_total_r == $past(flips_total_r) + 1'b1)
    else $error("flip total did not advance by one");

  a_kind_has_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (result_r.kind == KIND_PARTIAL || result_r.kind == KIND_FULL)
      |-> result_r.have)
    else $error("presented flip without a region");

  a_empty_rect_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !result_r.have |-> result_r.width == '0 && result_r.height == '0 &&
      result_r.left == '0 && result_r.top == '0)
    else $error("empty region reports a rectangle");

  a_disabled_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !enable_r |=> result_r.kind == KIND_NONE && !result_r.have)
    else $error("disabled event produced a classification");
`endif

endmodule

// ===== rtl/drt_event.sv =====
module drt_event
  import drt_pkg::*;
(
  input  op_t                op,
  input  rect_t              rect,
  input  region_t            region,
  input  logic               enable,
  input  logic               partial_ok,
  input  logic [DIM_W-1:0]   surf_w,
  input  logic [DIM_W-1:0]   surf_h,
  input  logic [FULL_W-1:0]  full_area,
  output region_t            region_nxt,
  output result_t            result,
  output logic [AREA_W-1:0]  area
);

  logic signed [17:0] xs, ys, ws, hs, xe, ye, x0, y0, x1, y1, sw_s, sh_s;
  logic               hit;
  logic [POS_W-1:0]   cx0, cy0, mx0, my0;
  logic [DIM_W-1:0]   cx1, cy1, mw, mh, mul_a, mul_b;
  logic [DIM_W:0]     rx1_old, ry1_old, mx1, my1;
  logic [30:0]        area20, full19;
  logic               promote, is_mark, covers;
  region_t            post;

  // Clip the incoming rectangle to the surface
  always_comb begin
    xs   = {{2{rect.left[15]}}, rect.left};
    ys   = {{2{rect.top[15]}}, rect.top};
    ws   = {{2{rect.width[15]}}, rect.width};
    hs   = {{2{rect.height[15]}}, rect.height};
    sw_s = {5'b0, surf_w};
    sh_s = {5'b0, surf_h};
    xe   = xs + ws;
    ye   = ys + hs;
    x0   = xs[17] ? '0 : xs;
    y0   = ys[17] ? '0 : ys;
    x1   = (xe > sw_s) ? sw_s : xe;
    y1   = (ye > sh_s) ? sh_s : ye;
    hit  = (ws > 18'sd0) && (hs > 18'sd0) && (x1 > x0) && (y1 > y0);
    cx0  = x0[POS_W-1:0];
    cy0  = y0[POS_W-1:0];
    cx1  = x1[DIM_W-1:0];
    cy1  = y1[DIM_W-1:0];
  end

  // Bounding box of the clipped rectangle and the stored region
  always_comb begin
    rx1_old = {2'b0, region.left} + {1'b0, region.width};
    ry1_old = {2'b0, region.top} + {1'b0, region.height};
    mx0     = (cx0 < region.left) ? cx0 : region.left;
    my0     = (cy0 < region.top) ? cy0 : region.top;
    mx1     = ({1'b0, cx1} > rx1_old) ? {1'b0, cx1} : rx1_old;
    my1     = ({1'b0, cy1} > ry1_old) ? {1'b0, cy1} : ry1_old;
    mw      = DIM_W'(mx1 - {2'b0, mx0});
    mh      = DIM_W'(my1 - {2'b0, my0});
  end

  // Share one multiplier between the merge promotion check and the flip area
  always_comb begin
    is_mark = (op == OP_MARK_RECT);
    mul_a   = is_mark ? mw : region.width;
    mul_b   = is_mark ? mh : region.height;
    area    = mul_a * mul_b;
    // area*100 >= full*95 reduces to area*20 >= full*19
    area20  = (31'(area) << 4) + (31'(area) << 2);
    full19  = (31'(full_area) << 4) + (31'(full_area) << 1) + 31'(full_area);
    promote = (full_area != '0) && (area20 >= full19);
  end

  // Apply the event, read back the visible region, classify a flip
  always_comb begin
    post = region;
    case (op)
      OP_MARK_RECT: begin
        if (enable && hit && !region.full) begin
          if (region.width == '0 || region.height == '0) begin
            post = '{left: cx0, top: cy0, width: cx1 - {1'b0, cx0},
                     height: cy1 - {1'b0, cy0}, full: 1'b0};
          end else begin
            post = '{left: mx0, top: my0, width: mw, height: mh, full: promote};
          end
        end
      end
      OP_MARK_FULL: begin
        if (enable) post.full = 1'b1;
      end
      OP_CLEAR: begin
        post = '0;
      end
      default: begin
        post = region;
      end
    endcase

    result      = '0;
    result.kind = KIND_NONE;
    if (enable && post.full) begin
      result.have   = 1'b1;
      result.width  = surf_w;
      result.height = surf_h;
    end else if (enable && post.width != '0 && post.height != '0) begin
      result.have   = 1'b1;
      result.left   = post.left;
      result.top    = post.top;
      result.width  = post.width;
      result.height = post.height;
    end

    region_nxt = post;
    covers = post.full || (result.left == '0 && result.top == '0 &&
                           result.width == surf_w && result.height == surf_h);
    if (op == OP_FLIP && enable) begin
      region_nxt = '0;
      if (!result.have) begin
        result.kind = KIND_EMPTY;
      end else if (!covers && partial_ok) begin
        result.kind = KIND_PARTIAL;
      end else begin
        result.kind   = KIND_FULL;
        result.left   = '0;
        result.top    = '0;
        result.width  = surf_w;
        result.height = surf_h;
      end
    end
  end

endmodule
